// ===== rtl/scl_pkg.sv =====
// ----------------------------------------------------------------------------
// scl_pkg
// shared constants, token record and character class helper for the
// shell command tokenizer
// ----------------------------------------------------------------------------
package scl_pkg;

    localparam int POS_BITS_DEFAULT = 16;
    localparam int TOK_W            = 16;
    localparam int FIFO_DEPTH       = 4;

    // lexer modes
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_GT    = 3'd1;
    localparam logic [2:0] MODE_AMP   = 3'd2;
    localparam logic [2:0] MODE_BAR   = 3'd3;
    localparam logic [2:0] MODE_QUOTE = 3'd4;
    localparam logic [2:0] MODE_WORD  = 3'd5;

    // token kinds
    localparam logic [3:0] K_EOF     = 4'd0;
    localparam logic [3:0] K_COMMENT = 4'd1;
    localparam logic [3:0] K_RIN     = 4'd2;
    localparam logic [3:0] K_ROUT    = 4'd3;
    localparam logic [3:0] K_APPEND  = 4'd4;
    localparam logic [3:0] K_BG      = 4'd5;
    localparam logic [3:0] K_AND     = 4'd6;
    localparam logic [3:0] K_PIPE    = 4'd7;
    localparam logic [3:0] K_OR      = 4'd8;
    localparam logic [3:0] K_NL      = 4'd9;
    localparam logic [3:0] K_STRING  = 4'd10;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    typedef struct packed {
        logic [3:0]       kind;
        logic [TOK_W-1:0] start;
        logic [TOK_W-1:0] length;
        logic [TOK_W-1:0] line;
        logic             last;
    } token_t;

    function automatic logic word_char(input logic [7:0] c);
        logic r;
        r = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DOT ||
            c == CH_SLASH || c == CH_DASH || c == CH_COLON || c == CH_EQ;
        return r;
    endfunction

endpackage

// ===== rtl/scl_if.sv =====
// ----------------------------------------------------------------------------
// scl_if
// valid/ready channels for characters in and tokens out
// ----------------------------------------------------------------------------
interface scl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface scl_token_if;
    logic                      valid;
    logic                      ready;
    logic [3:0]                token_kind;
    logic [scl_pkg::TOK_W-1:0] token_start;
    logic [scl_pkg::TOK_W-1:0] token_length;
    logic [scl_pkg::TOK_W-1:0] line_count;
    logic                      last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output line_count, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input line_count, input last_of_run,
                    output ready);
endinterface

// ===== rtl/scl_lex_step.sv =====
// ----------------------------------------------------------------------------
// scl_lex_step
// next-state and token logic for one character
// ----------------------------------------------------------------------------
module scl_lex_step #(
    parameter int POS_BITS = scl_pkg::POS_BITS_DEFAULT
) (
    input  logic [7:0]                c,
    input  logic [2:0]                mode,
    input  logic [POS_BITS-1:0]       pos,
    input  logic [POS_BITS-1:0]       pstart,
    input  logic [scl_pkg::TOK_W-1:0] plen,
    input  logic [scl_pkg::TOK_W-1:0] nl,
    output logic [2:0]                mode_next,
    output logic [POS_BITS-1:0]       pos_next,
    output logic [POS_BITS-1:0]       pstart_next,
    output logic [scl_pkg::TOK_W-1:0] plen_next,
    output logic [scl_pkg::TOK_W-1:0] nl_next,
    output logic [1:0]                n_tok,
    output scl_pkg::token_t           tok0,
    output scl_pkg::token_t           tok1
);

    localparam int TW = scl_pkg::TOK_W;

    logic [POS_BITS-1:0] pos_inc;
    logic [TW-1:0]       plen_inc;

    // fresh handling of c
    logic                f_valid;
    scl_pkg::token_t     f_tok;
    logic [2:0]          f_mode;
    logic [POS_BITS-1:0] f_pos;
    logic [POS_BITS-1:0] f_start;
    logic [TW-1:0]       f_len;
    logic [TW-1:0]       f_nl;

    // pending-token handling
    logic                p_valid;
    scl_pkg::token_t     p_tok;
    logic                do_fresh;

    assign pos_inc  = (pos == '1) ? pos : pos + 1'b1;
    assign plen_inc = (plen == '1) ? plen : plen + 1'b1;

    always_comb
    begin
        f_valid     = 1'b0;
        f_tok       = '0;
        f_tok.start = TW'(pos);
        f_tok.line  = nl;
        f_tok.last  = 1'b1;
        f_mode      = scl_pkg::MODE_IDLE;
        f_pos       = pos_inc;
        f_start     = pstart;
        f_len       = plen;
        f_nl        = nl;
        case (c) inside
            scl_pkg::CH_NUL:
            begin
                f_valid      = 1'b1;
                f_tok.kind   = scl_pkg::K_EOF;
                f_tok.length = '0;
                f_pos        = '0;
            end
            scl_pkg::CH_SPACE, scl_pkg::CH_TAB:
            begin
                f_valid = 1'b0;
            end
            scl_pkg::CH_HASH:
            begin
                f_valid      = 1'b1;
                f_tok.kind   = scl_pkg::K_COMMENT;
                f_tok.length = TW'(1);
            end
            scl_pkg::CH_LT:
            begin
                f_valid      = 1'b1;
                f_tok.kind   = scl_pkg::K_RIN;
                f_tok.length = TW'(1);
            end
            scl_pkg::CH_NL:
            begin
                f_nl         = nl + 1'b1;
                f_valid      = 1'b1;
                f_tok.kind   = scl_pkg::K_NL;
                f_tok.length = TW'(1);
                f_tok.line   = nl + 1'b1;
            end
            scl_pkg::CH_GT:
            begin
                f_mode  = scl_pkg::MODE_GT;
                f_start = pos;
            end
            scl_pkg::CH_AMP:
            begin
                f_mode  = scl_pkg::MODE_AMP;
                f_start = pos;
            end
            scl_pkg::CH_BAR:
            begin
                f_mode  = scl_pkg::MODE_BAR;
                f_start = pos;
            end
            scl_pkg::CH_QUOTE:
            begin
                f_mode  = scl_pkg::MODE_QUOTE;
                f_start = pos_inc;
                f_len   = '0;
            end
            default:
            begin
                f_mode  = scl_pkg::MODE_WORD;
                f_start = pos;
                f_len   = TW'(1);
            end
        endcase
    end

    always_comb
    begin
        p_valid      = 1'b0;
        p_tok        = '0;
        p_tok.start  = TW'(pstart);
        p_tok.line   = nl;
        p_tok.length = TW'(1);
        do_fresh     = 1'b0;
        mode_next    = mode;
        pos_next     = pos;
        pstart_next  = pstart;
        plen_next    = plen;
        nl_next      = nl;
        unique case (mode)
            scl_pkg::MODE_GT, scl_pkg::MODE_AMP, scl_pkg::MODE_BAR:
            begin
                mode_next = scl_pkg::MODE_IDLE;
                p_valid   = 1'b1;
                if ((mode == scl_pkg::MODE_GT  && c == scl_pkg::CH_GT) ||
                    (mode == scl_pkg::MODE_AMP && c == scl_pkg::CH_AMP) ||
                    (mode == scl_pkg::MODE_BAR && c == scl_pkg::CH_BAR))
                begin
                    p_tok.length = TW'(2);
                    pos_next     = pos_inc;
                    p_tok.kind   = (mode == scl_pkg::MODE_GT)  ? scl_pkg::K_APPEND :
                                   (mode == scl_pkg::MODE_AMP) ? scl_pkg::K_AND :
                                                                 scl_pkg::K_OR;
                end
                else
                begin
                    do_fresh   = 1'b1;
                    p_tok.kind = (mode == scl_pkg::MODE_GT)  ? scl_pkg::K_ROUT :
                                 (mode == scl_pkg::MODE_AMP) ? scl_pkg::K_BG :
                                                               scl_pkg::K_PIPE;
                end
            end
            scl_pkg::MODE_QUOTE, scl_pkg::MODE_WORD:
            begin
                p_tok.kind   = scl_pkg::K_STRING;
                p_tok.length = plen;
                if (mode == scl_pkg::MODE_QUOTE && c == scl_pkg::CH_QUOTE)
                begin
                    mode_next = scl_pkg::MODE_IDLE;
                    p_valid   = 1'b1;
                    pos_next  = pos_inc;
                end
                else if ((mode == scl_pkg::MODE_QUOTE && c == scl_pkg::CH_NUL) ||
                         (mode == scl_pkg::MODE_WORD && !scl_pkg::word_char(c)))
                begin
                    mode_next = scl_pkg::MODE_IDLE;
                    p_valid   = 1'b1;
                    do_fresh  = 1'b1;
                end
                else
                begin
                    plen_next = plen_inc;
                    pos_next  = pos_inc;
                end
            end
            default:
            begin
                mode_next = scl_pkg::MODE_IDLE;
                do_fresh  = 1'b1;
            end
        endcase

        if (do_fresh)
        begin
            mode_next   = f_mode;
            pos_next    = f_pos;
            pstart_next = f_start;
            plen_next   = f_len;
            nl_next     = f_nl;
        end

        // order: pending token first, then the token of the fresh character
        n_tok      = {1'b0, p_valid} + {1'b0, do_fresh & f_valid};
        tok0       = p_valid ? p_tok : f_tok;
        tok0.last  = (n_tok == 2'd1);
        tok1       = f_tok;
        tok1.last  = 1'b1;
    end

endmodule

// ===== rtl/scl_fifo.sv =====
// ----------------------------------------------------------------------------
// scl_fifo
// token queue taking up to two tokens and giving one per cycle when popped
// ----------------------------------------------------------------------------
module scl_fifo #(
    parameter int DEPTH = scl_pkg::FIFO_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      push,
    input  scl_pkg::token_t din0,
    input  scl_pkg::token_t din1,
    input  logic            pop,
    output scl_pkg::token_t dout,
    output logic            not_empty,
    output logic            room2
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    scl_pkg::token_t mem [DEPTH];
    logic [AW-1:0]   wr_reg;
    logic [AW-1:0]   rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic [AW-1:0]   wr_next;
    logic [AW-1:0]   rd_next;
    logic [CW-1:0]   cnt_next;
    logic [AW-1:0]   wr_plus1;

    assign wr_plus1  = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
    assign not_empty = (cnt_reg != '0);
    assign room2     = (cnt_reg <= CW'(DEPTH - 2));
    assign dout      = mem[rd_reg];

    always_comb
    begin
        wr_next = wr_reg;
        if (push == 2'd1)
        begin
            wr_next = wr_plus1;
        end
        else if (push == 2'd2)
        begin
            wr_next = (wr_plus1 == AW'(DEPTH - 1)) ? '0 : wr_plus1 + 1'b1;
        end
        rd_next = rd_reg;
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push != 2'd0)
        begin
            mem[wr_reg] <= din0;
        end
        if (push == 2'd2)
        begin
            mem[wr_plus1] <= din1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/shell_command_tokenizer.sv =====
// ----------------------------------------------------------------------------
// shell_command_tokenizer
// streaming lexer: one character in, zero to two tokens out
// ----------------------------------------------------------------------------
// queueing: a token enters the token queue on the transfer of the character
//   that completes it; a second token from the same character follows it
// throughput: one character per cycle, set by the combinational lexer update;
//   input stalls only while the four-entry token queue has under two free slots
// reset: asynchronous, clears lexer mode, positions, lengths, line counter
//   and the token queue
// ----------------------------------------------------------------------------
module shell_command_tokenizer #(
    parameter int POS_BITS = scl_pkg::POS_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    scl_char_if.sink     chars,
    scl_token_if.source  tokens
);

    localparam int TW = scl_pkg::TOK_W;

    // lexer state
    logic [2:0]          mode_reg;
    logic [POS_BITS-1:0] pos_reg;
    logic [POS_BITS-1:0] pstart_reg;
    logic [TW-1:0]       plen_reg;
    logic [TW-1:0]       nl_reg;

    logic [2:0]          mode_next;
    logic [POS_BITS-1:0] pos_next;
    logic [POS_BITS-1:0] pstart_next;
    logic [TW-1:0]       plen_next;
    logic [TW-1:0]       nl_next;

    logic [1:0]          n_tok;
    scl_pkg::token_t     tok0;
    scl_pkg::token_t     tok1;
    scl_pkg::token_t     head;
    logic                room2;
    logic                not_empty;
    logic                in_xfer;
    logic                out_xfer;

    // a character may produce two tokens, so take it only with two free slots
    assign chars.ready = room2;
    assign in_xfer     = chars.valid && room2;
    assign out_xfer    = tokens.valid && tokens.ready;

    scl_lex_step #(
        .POS_BITS (POS_BITS)
    ) u_step (
        .c           (chars.char_in),
        .mode        (mode_reg),
        .pos         (pos_reg),
        .pstart      (pstart_reg),
        .plen        (plen_reg),
        .nl          (nl_reg),
        .mode_next   (mode_next),
        .pos_next    (pos_next),
        .pstart_next (pstart_next),
        .plen_next   (plen_next),
        .nl_next     (nl_next),
        .n_tok       (n_tok),
        .tok0        (tok0),
        .tok1        (tok1)
    );

    // state only advances on a character transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= scl_pkg::MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            nl_reg     <= '0;
        end
        else if (in_xfer)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            nl_reg     <= nl_next;
        end
    end

    // token queue decouples the character side from a stalled token sink
    scl_fifo #(
        .DEPTH (scl_pkg::FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer ? n_tok : 2'd0),
        .din0      (tok0),
        .din1      (tok1),
        .pop       (out_xfer),
        .dout      (head),
        .not_empty (not_empty),
        .room2     (room2)
    );

    assign tokens.valid        = not_empty;
    assign tokens.token_kind   = head.kind;
    assign tokens.token_start  = head.start;
    assign tokens.token_length = head.length;
    assign tokens.line_count   = head.line;
    assign tokens.last_of_run  = head.last;

endmodule

// ===== sim/shell_command_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// shell_command_tokenizer_tb
// self-checking bench for the streaming shell tokenizer: a scripted opening
// sequence of characters, then random command lines under bursty sending,
// receiver stalls and one long receiver hold-off. every token is compared
// with a hand-written token or an in-bench lexer model
// ----------------------------------------------------------------------------
module shell_command_tokenizer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import scl_pkg::*;

    localparam int POS_W       = POS_BITS_DEFAULT;
    localparam int RAND_CHARS  = 1920;    // random characters, blanks included
    localparam int HOLD_CYCLES = 400;     // one long receiver hold-off
    localparam int STALL_LIMIT = 4000;    // cycles without any transfer
    localparam int DRAIN_WAIT  = 10;      // quiet cycles after the last token

    typedef enum int {RX_OPEN, RX_COIN, RX_THIRD, RX_MOSTLY} rx_style_e;

    typedef struct {
        logic [7:0] ch;
        bit         typed;   // token written out by hand below
        token_t     tok;
    } script_row_t;

    logic clk;
    logic rst_n;

    scl_char_if  char_ch();
    scl_token_if token_ch();

    shell_command_tokenizer #(.POS_BITS(POS_W)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (char_ch),
        .tokens (token_ch)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------------
    // lexer model: mirrors the tokenizer state and computes the tokens that
    // each transferred character produces
    // ------------------------------------------------------------------------
    logic [2:0]       lx_mode;
    logic [POS_W-1:0] cur_pos;      // position of the next character in the line
    logic [POS_W-1:0] tok_start;    // start of the token being collected
    logic [15:0]      tok_len;      // chars of the pending word or string
    logic [15:0]      line_total;   // newline tokens so far, wraps

    token_t char_tokens[$];         // tokens caused by the current character
    token_t tokens_due[$];          // tokens still owed by the block, oldest first

    function automatic logic [POS_W-1:0] pos_next(input logic [POS_W-1:0] p);
        return (p == {POS_W{1'b1}}) ? p : p + 1'b1;
    endfunction

    function automatic bit is_word_char(input logic [7:0] c);
        bit alpha;
        bit digit;
        alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
        digit = (c >= 8'h30 && c <= 8'h39);
        return alpha || digit || c == CH_UNDER || c == CH_DOT || c == CH_SLASH ||
               c == CH_DASH || c == CH_COLON || c == CH_EQ;
    endfunction

    task automatic put_token(input logic [3:0] kind, input logic [POS_W-1:0] at,
                             input logic [15:0] len);
        token_t t;
        t.kind   = kind;
        t.start  = TOK_W'(at);   // wide positions keep only the low bits
        t.length = len;
        t.line   = line_total;
        t.last   = 1'b0;
        char_tokens.push_back(t);
    endtask

    // character seen with nothing pending
    task automatic lex_fresh(input logic [7:0] c);
        case (c)
            CH_NUL:
            begin
                put_token(K_EOF, cur_pos, 16'd0);
                cur_pos = '0;
            end
            CH_SPACE, CH_TAB: ;
            CH_HASH:  put_token(K_COMMENT, cur_pos, 16'd1);
            CH_LT:    put_token(K_RIN, cur_pos, 16'd1);
            CH_NL:
            begin
                line_total = line_total + 16'd1;
                put_token(K_NL, cur_pos, 16'd1);
            end
            CH_GT:
            begin
                lx_mode   = MODE_GT;
                tok_start = cur_pos;
            end
            CH_AMP:
            begin
                lx_mode   = MODE_AMP;
                tok_start = cur_pos;
            end
            CH_BAR:
            begin
                lx_mode   = MODE_BAR;
                tok_start = cur_pos;
            end
            CH_QUOTE:
            begin
                // string text starts after the opening quote
                lx_mode   = MODE_QUOTE;
                tok_start = pos_next(cur_pos);
                tok_len   = 16'd0;
            end
            default:
            begin
                lx_mode   = MODE_WORD;
                tok_start = cur_pos;
                tok_len   = 16'd1;
            end
        endcase
        if (c != CH_NUL)
            cur_pos = pos_next(cur_pos);
    endtask

    // pending '>', '&' or '|': pair on a repeat, else single token and a fresh look
    task automatic lex_pair(input logic [7:0] c, input logic [7:0] twin,
                            input logic [3:0] single_kind, input logic [3:0] pair_kind);
        lx_mode = MODE_IDLE;
        if (c == twin)
        begin
            put_token(pair_kind, tok_start, 16'd2);
            cur_pos = pos_next(cur_pos);
        end
        else
        begin
            put_token(single_kind, tok_start, 16'd1);
            lex_fresh(c);
        end
    endtask

    task automatic lex_char(input logic [7:0] c);
        char_tokens.delete();
        case (lx_mode)
            MODE_GT:  lex_pair(c, CH_GT, K_ROUT, K_APPEND);
            MODE_AMP: lex_pair(c, CH_AMP, K_BG, K_AND);
            MODE_BAR: lex_pair(c, CH_BAR, K_PIPE, K_OR);
            MODE_QUOTE:
            begin
                if (c == CH_QUOTE)
                begin
                    lx_mode = MODE_IDLE;
                    put_token(K_STRING, tok_start, tok_len);
                    cur_pos = pos_next(cur_pos);
                end
                else if (c == CH_NUL)
                begin
                    // unterminated quote closes at end of line
                    lx_mode = MODE_IDLE;
                    put_token(K_STRING, tok_start, tok_len);
                    lex_fresh(c);
                end
                else
                begin
                    if (tok_len != 16'hFFFF)
                        tok_len = tok_len + 16'd1;
                    cur_pos = pos_next(cur_pos);
                end
            end
            MODE_WORD:
            begin
                if (is_word_char(c))
                begin
                    if (tok_len != 16'hFFFF)
                        tok_len = tok_len + 16'd1;
                    cur_pos = pos_next(cur_pos);
                end
                else
                begin
                    lx_mode = MODE_IDLE;
                    put_token(K_STRING, tok_start, tok_len);
                    lex_fresh(c);
                end
            end
            default:
            begin
                lx_mode = MODE_IDLE;
                lex_fresh(c);
            end
        endcase
        if (char_tokens.size() > 0)
            char_tokens[char_tokens.size()-1].last = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // token checker
    // ------------------------------------------------------------------------
    int mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // sampled at the edge, before any update of that edge lands
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n === 1'b1 && token_ch.valid === 1'b1 && token_ch.ready === 1'b1)
        begin
            if (tokens_due.size() == 0)
                report_mismatch($sformatf("token with nothing expected: kind %0d start %0d",
                                          token_ch.token_kind, token_ch.token_start));
            else
            begin
                want = tokens_due.pop_front();
                check_field("kind", 16'(token_ch.token_kind), 16'(want.kind));
                check_field("start", token_ch.token_start, want.start);
                check_field("length", token_ch.token_length, want.length);
                check_field("line", token_ch.line_count, want.line);
                check_field("last", 16'(token_ch.last_of_run), 16'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: segments of different stall styles and one long hold-off on
    // request
    // ------------------------------------------------------------------------
    logic      hold_req  = 1'b0;
    bit        hold_done = 1'b0;
    int        hold_left = 0;
    int        seg_left  = 0;
    int        rx_tick   = 0;
    rx_style_e rx_style  = RX_OPEN;

    initial
    begin
        token_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_tick++;
            if (rst_n !== 1'b1)
                token_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                token_ch.ready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                // long hold-off so the token queue fills and the input stalls
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                token_ch.ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    rx_style = rx_style_e'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 150);
                end
                seg_left--;
                case (rx_style)
                    RX_OPEN:  token_ch.ready <= 1'b1;
                    RX_COIN:  token_ch.ready <= 1'($urandom_range(0, 1));
                    RX_THIRD: token_ch.ready <= (rx_tick % 3 == 0);
                    default:  token_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing transfers for too long
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((char_ch.valid === 1'b1 && char_ch.ready === 1'b1) ||
                (token_ch.valid === 1'b1 && token_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    int         burst_left   = 0;
    int         no_gap_items = 0;
    int         rand_chars   = 0;
    logic [7:0] cmd_bytes[$];

    // bursts of random length with random gaps; no gaps while the receiver
    // is held off
    task automatic pace_sender();
        int gap;
        if (no_gap_items > 0)
            no_gap_items--;
        else if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 8);
            char_ch.valid   <= 1'b0;
            char_ch.char_in <= 8'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // offer one character, wait for its transfer, then book its tokens
    task automatic send_char(input logic [7:0] c, input bit typed, input token_t tok);
        char_ch.valid   <= 1'b1;
        char_ch.char_in <= c;
        do
            @(posedge clk);
        while (char_ch.ready !== 1'b1);
        lex_char(c);
        if (typed)
            tokens_due.push_back(tok);
        else
            foreach (char_tokens[i])
                tokens_due.push_back(char_tokens[i]);
        pace_sender();
    endtask

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range(8'h61, 8'h7A));
            1:       return 8'($urandom_range(8'h41, 8'h5A));
            2:       return 8'($urandom_range(8'h30, 8'h39));
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return CH_UNDER;
                    1:       return CH_DOT;
                    2:       return CH_SLASH;
                    3:       return CH_DASH;
                    4:       return CH_COLON;
                    default: return CH_EQ;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] pick_text_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE);
        return b;
    endfunction

    // one random command line: mostly well formed, some raw noise
    task automatic build_command();
        int ntok;
        int n;
        cmd_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            repeat (n) cmd_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            ntok = $urandom_range(1, 10);
            repeat (ntok)
            begin
                // blanks between tokens, sometimes none so tokens touch
                n = $urandom_range(0, 2);
                repeat (n) cmd_bytes.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        // word, sometimes led by a byte above 127
                        cmd_bytes.push_back($urandom_range(0, 3) == 0
                                            ? 8'($urandom_range(128, 255))
                                            : pick_word_char());
                        n = $urandom_range(0, 7);
                        repeat (n) cmd_bytes.push_back(pick_word_char());
                    end
                    4, 5:
                    begin
                        cmd_bytes.push_back(CH_QUOTE);
                        n = $urandom_range(0, 6);
                        repeat (n) cmd_bytes.push_back(pick_text_char());
                        if ($urandom_range(0, 7) != 0)
                            cmd_bytes.push_back(CH_QUOTE);
                    end
                    6:
                    begin
                        case ($urandom_range(0, 2))
                            0:       cmd_bytes.push_back(CH_GT);
                            1:       cmd_bytes.push_back(CH_AMP);
                            default: cmd_bytes.push_back(CH_BAR);
                        endcase
                        if ($urandom_range(0, 1))
                            cmd_bytes.push_back(cmd_bytes[cmd_bytes.size()-1]);
                    end
                    7:       cmd_bytes.push_back($urandom_range(0, 1) ? CH_LT : CH_HASH);
                    8:       cmd_bytes.push_back(CH_NL);
                    default: cmd_bytes.push_back(8'($urandom_range(1, 255)));
                endcase
            end
        end
        cmd_bytes.push_back(CH_NUL);
    endtask

    initial
    begin
        script_row_t opening_script[26];
        int          line_no;

        // hand-written tokens only where the answer is plain to see
        opening_script = '{
            '{CH_NUL,   1'b1, token_t'{K_EOF,     16'd0,  16'd0, 16'd0, 1'b1}},
            '{CH_HASH,  1'b1, token_t'{K_COMMENT, 16'd0,  16'd1, 16'd0, 1'b1}},
            '{CH_LT,    1'b1, token_t'{K_RIN,     16'd1,  16'd1, 16'd0, 1'b1}},
            '{CH_NL,    1'b1, token_t'{K_NL,      16'd2,  16'd1, 16'd1, 1'b1}},
            '{CH_SPACE, 1'b0, '0},
            '{CH_TAB,   1'b0, '0},
            '{CH_GT,    1'b0, '0},
            '{CH_GT,    1'b1, token_t'{K_APPEND,  16'd5,  16'd2, 16'd1, 1'b1}},
            '{CH_GT,    1'b0, '0},
            '{8'h61,    1'b0, '0},    // single '>' then a word starts
            '{8'h62,    1'b0, '0},
            '{CH_AMP,   1'b0, '0},    // word ended by an operator
            '{CH_AMP,   1'b1, token_t'{K_AND,     16'd10, 16'd2, 16'd1, 1'b1}},
            '{CH_AMP,   1'b0, '0},
            '{CH_BAR,   1'b0, '0},    // background, then pipe pending
            '{CH_BAR,   1'b1, token_t'{K_OR,      16'd13, 16'd2, 16'd1, 1'b1}},
            '{CH_BAR,   1'b0, '0},
            '{CH_QUOTE, 1'b0, '0},    // pipe, then a quote opens
            '{CH_QUOTE, 1'b0, '0},    // empty string
            '{CH_QUOTE, 1'b0, '0},
            '{8'hFF,    1'b0, '0},
            '{CH_NUL,   1'b0, '0},    // unterminated quote closed by end of line
            '{8'h80,    1'b0, '0},    // high byte starts a word
            '{CH_NL,    1'b0, '0},
            '{CH_BAR,   1'b0, '0},
            '{CH_NUL,   1'b0, '0}     // pending pipe flushed before the end token
        };

        rst_n           <= 1'b0;
        char_ch.valid   <= 1'b0;
        char_ch.char_in <= 8'h00;
        lx_mode    = MODE_IDLE;
        cur_pos    = '0;
        tok_start  = '0;
        tok_len    = 16'd0;
        line_total = 16'd0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_script[i])
            send_char(opening_script[i].ch, opening_script[i].typed, opening_script[i].tok);

        // random command lines
        line_no = 0;
        while (rand_chars < RAND_CHARS)
        begin
            build_command();
            line_no++;
            if (line_no == 30)
            begin
                hold_req    <= 1'b1;
                no_gap_items = 80;
            end
            foreach (cmd_bytes[i])
            begin
                send_char(cmd_bytes[i], 1'b0, '0);
                rand_chars++;
            end
        end

        char_ch.valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
